@@ rtl/bzc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and helpers for the BLDC zero-cross commutation timer.
// No dependencies; imported by bzc_step and bldc_zero_cross_commutation_timer.
package bzc_pkg;

    // Backlog length in bits: the backlog holds 2^(BACKLOG_LEN-1) periods.
    localparam int BACKLOG_LEN_DEF = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_PRESET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_SHIFT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADVANCE_ZERO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_ADVANCE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANKING       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_COUNT     = 3'd5;

    // Event kinds.
    localparam logic [1:0] KIND_ZERO_CROSS = 2'd0;
    localparam logic [1:0] KIND_OVERFLOW   = 2'd1;
    localparam logic [1:0] KIND_START      = 2'd2;

    // Timer actions.
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_LOAD = 2'd1;
    localparam logic [1:0] ACT_ADD  = 2'd2;

    localparam logic [15:0] ALL_ONES = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] capture;
        logic        detect_period;
        logic        settle_missed;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  timer_action;
        logic [15:0] timer_value;
        logic        arm_comparator;
        logic        stall_reset;
        logic        entered_commute;
        logic        in_commute;
        logic [15:0] period_preset;
        logic [15:0] average_period;
    } t_out_item;

    typedef struct packed {
        logic [15:0] startup_period_preset;
        logic [3:0]  error_shift;
        logic [15:0] advance_after_zero;
        logic [15:0] fixed_advance;
        logic [7:0]  blanking_counts;
        logic [7:0]  lock_count;
    } t_cfg;

    typedef struct packed {
        logic        waiting;
        logic        commute;
        logic        armed;
        logic [15:0] period;
        logic [15:0] zero_time;
        logic [15:0] prev_zero_time;
        logic [15:0] after_zero_reload;
        logic [7:0]  lock_cd;
    } t_state;

    // Backlog control from the step logic to the backlog store.
    typedef struct packed {
        logic        clear;
        logic        write;
        logic [15:0] value;
    } t_bl_ctl;

    function automatic logic [15:0] half_time(input logic [15:0] x);
        half_time = {1'b1, x[15:1]};
    endfunction

    function automatic logic [15:0] neg16(input logic [15:0] x);
        neg16 = (~x) + 16'd1;
    endfunction

endpackage

@@ rtl/bldc_zero_cross_commutation_timer.sv @@
`timescale 1ns / 1ps
// Sensorless BLDC commutation timer driven by back-EMF zero-cross events.
// Depends on bzc_pkg and bzc_step.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data): one beat per event,
//   a zero-cross with its captured count, a timer overflow, or a start.
//   Output channel (o_out_valid / i_out_stall / o_out_data): one beat per
//   input beat, in order, telling the timer what to do and the motor status.
//   Config channel (i_cfg_valid / o_cfg_ready, index, data): always ready;
//   write only while no event is in flight.
//
// Flow: an event is registered on entry, evaluated in one pass through
// bzc_step as it moves into the output register, and shows on the output
// from that register. One event per cycle is sustained while the output
// is not stalled; the loop through the state registers and the backlog
// read sets that figure. The backlog keeps 2^(BACKLOG_LEN-1) periods in
// a memory with a registered read port; the next slot is always read ahead.
//
// Reset: state clears to zero, registers take their defaults, no clearing
// pass is needed (a fill flag masks slots not yet written since start).
// Stall: when the output is held the input register is kept and o_in_stall
// rises; nothing is dropped, and state does not advance while held.
module bldc_zero_cross_commutation_timer #(
    parameter int BACKLOG_LEN = bzc_pkg::BACKLOG_LEN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  bzc_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output bzc_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bzc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bzc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import bzc_pkg::*;

    localparam int BL_SIZE = 1 << (BACKLOG_LEN - 1);
    localparam int PTR_W   = (BACKLOG_LEN > 1) ? BACKLOG_LEN - 1 : 1;
    localparam int TOT_W   = 15 + BACKLOG_LEN;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BL_SIZE - 1);

    // Configuration registers.
    t_cfg r_cfg;

    // Input and output stage registers.
    logic      r_in_valid;
    t_in_item  r_in_data;
    logic      r_out_valid;
    t_out_item r_out_data;

    // Motor timing state.
    t_state r_state;
    t_state n_state;

    // Backlog store.
    logic [15:0]      r_bl_mem [BL_SIZE];
    logic [15:0]      r_bl_rd;
    logic [PTR_W-1:0] r_bl_ptr;
    logic [PTR_W-1:0] n_bl_ptr;
    logic             r_bl_full;
    logic             n_bl_full;
    logic [TOT_W-1:0] r_bl_total;
    logic [TOT_W-1:0] n_bl_total;
    logic [15:0]      w_bl_old;

    t_out_item w_result;
    t_out_item n_out_data;
    t_bl_ctl   w_bl_ctl;
    logic      w_adv;

    assign o_cfg_ready = 1'b1;

    // Advance the held beat when the output register is free or draining.
    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    bzc_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_in_data),
        .o_state  (n_state),
        .o_result (w_result),
        .o_bl_ctl (w_bl_ctl)
    );

    // Slots not rewritten since the last start read as zero.
    assign w_bl_old = r_bl_full ? r_bl_rd : 16'd0;

    always_comb begin
        n_bl_ptr   = r_bl_ptr;
        n_bl_full  = r_bl_full;
        n_bl_total = r_bl_total;
        if (w_adv && w_bl_ctl.clear) begin
            n_bl_ptr   = '0;
            n_bl_full  = 1'b0;
            n_bl_total = '0;
        end else if (w_adv && w_bl_ctl.write) begin
            n_bl_ptr   = (r_bl_ptr == PTR_LAST) ? '0 : r_bl_ptr + PTR_W'(1);
            n_bl_full  = r_bl_full || (r_bl_ptr == PTR_LAST);
            n_bl_total = r_bl_total - TOT_W'(w_bl_old) + TOT_W'(w_bl_ctl.value);
        end
    end

    always_comb begin
        n_out_data                = w_result;
        n_out_data.average_period = 16'(n_bl_total >> BACKLOG_LEN);
    end

    // Backlog memory: one write port, one registered read at the next slot,
    // forwarding the write when both land on the same slot.
    always_ff @(posedge i_clk) begin
        if (w_adv && w_bl_ctl.write) begin
            r_bl_mem[r_bl_ptr] <= w_bl_ctl.value;
        end
        if (w_adv && w_bl_ctl.write && (r_bl_ptr == n_bl_ptr)) begin
            r_bl_rd <= w_bl_ctl.value;
        end else begin
            r_bl_rd <= r_bl_mem[n_bl_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.startup_period_preset <= 16'd49152;
            r_cfg.error_shift           <= 4'd3;
            r_cfg.advance_after_zero    <= 16'd0;
            r_cfg.fixed_advance         <= 16'd0;
            r_cfg.blanking_counts       <= 8'd32;
            r_cfg.lock_count            <= 8'd6;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_STARTUP_PRESET: r_cfg.startup_period_preset <= i_cfg_data;
                CFG_ERROR_SHIFT:    r_cfg.error_shift           <= i_cfg_data[3:0];
                CFG_ADVANCE_ZERO:   r_cfg.advance_after_zero    <= i_cfg_data;
                CFG_FIXED_ADVANCE:  r_cfg.fixed_advance         <= i_cfg_data;
                CFG_BLANKING:       r_cfg.blanking_counts       <= i_cfg_data[7:0];
                CFG_LOCK_COUNT:     r_cfg.lock_count            <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_bl_ptr    <= '0;
            r_bl_full   <= 1'b0;
            r_bl_total  <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_bl_ptr   <= n_bl_ptr;
            r_bl_full  <= n_bl_full;
            r_bl_total <= n_bl_total;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

    // The comparator is only armed while a zero-cross is awaited.
    a_armed_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.armed |-> r_state.waiting)
        else $error("comparator armed while not waiting for zero-cross");

    // Entering commute mode must leave the block in commute mode.
    a_entered_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.entered_commute) |-> o_out_data.in_commute)
        else $error("entered commute without commute mode");

    // A fresh backlog (pointer home, not wrapped) sums to zero.
    a_backlog_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_bl_full && r_bl_ptr == '0) |-> (r_bl_total == '0))
        else $error("backlog total nonzero on empty backlog");

    // A held input beat is kept until it moves to the output.
    a_in_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> r_in_valid)
        else $error("input beat lost while output stalled");

endmodule

@@ rtl/bzc_step.sv @@
`timescale 1ns / 1ps
// Next-state and result logic for one event of the commutation timer.
// Depends on bzc_pkg; the backlog store and registers live in the top level.
module bzc_step (
    input  bzc_pkg::t_cfg      i_cfg,
    input  bzc_pkg::t_state    i_state,
    input  bzc_pkg::t_in_item  i_item,
    output bzc_pkg::t_state    o_state,
    output bzc_pkg::t_out_item o_result,
    output bzc_pkg::t_bl_ctl   o_bl_ctl
);
    import bzc_pkg::*;

    always_comb begin
        t_state              s;
        logic [1:0]          action;
        logic [15:0]         value;
        logic                stall;
        logic                entered;
        logic                commutate;
        logic [15:0]         expected;
        logic [15:0]         avg;
        logic [15:0]         err;
        logic [16:0]         err_ext;
        logic [16:0]         mag;
        logic [15:0]         thr;
        logic                good;
        logic [15:0]         period_new;

        s          = i_state;
        action     = ACT_NONE;
        value      = '0;
        stall      = 1'b0;
        entered    = 1'b0;
        commutate  = 1'b0;
        o_bl_ctl   = '0;
        expected   = half_time(i_state.period);
        avg        = '0;
        err        = '0;
        err_ext    = '0;
        mag        = '0;
        thr        = '0;
        good       = 1'b0;
        period_new = i_state.period;

        if (i_item.kind == KIND_START) begin
            s.lock_cd           = i_cfg.lock_count;
            s.period            = i_cfg.startup_period_preset;
            s.zero_time         = i_cfg.startup_period_preset;
            s.after_zero_reload = half_time(i_cfg.startup_period_preset);
            s.waiting           = 1'b0;
            s.armed             = 1'b0;
            s.commute           = 1'b0;
            o_bl_ctl.clear      = 1'b1;
            action              = ACT_LOAD;
            value               = i_cfg.startup_period_preset;
        end else if (i_item.kind == KIND_ZERO_CROSS) begin
            if (i_state.waiting && i_state.armed) begin
                s.armed          = 1'b0;
                s.prev_zero_time = i_state.zero_time;
                s.zero_time      = (i_item.capture <= i_state.period) ?
                                   i_state.period : i_item.capture;
                if (i_state.commute) begin
                    action = ACT_LOAD;
                    value  = i_state.after_zero_reload;
                end
                if (!i_state.commute) begin
                    s.lock_cd = i_state.lock_cd - 8'd1;
                    if (s.lock_cd == 8'd0) begin
                        s.commute = 1'b1;
                        entered   = 1'b1;
                    end
                end
                stall     = 1'b1;
                s.waiting = 1'b0;
            end
        end else if (i_item.kind == KIND_OVERFLOW) begin
            // Missed zero-cross: drop lock progress before commutating.
            if (i_state.waiting) begin
                s.armed          = 1'b0;
                s.prev_zero_time = i_state.zero_time;
                s.lock_cd        = i_cfg.lock_count;
                if (i_state.commute) begin
                    s.zero_time = ALL_ONES;
                end
            end
            commutate = 1'b1;
        end

        if (commutate) begin
            if (i_item.detect_period) begin
                action = ACT_ADD;
                value  = i_state.period + {8'd0, i_cfg.blanking_counts};
                if (!i_item.settle_missed) begin
                    s.armed   = 1'b1;
                    s.waiting = 1'b1;
                end
            end else begin
                avg     = half_time(s.zero_time) + half_time(s.prev_zero_time);
                err     = avg - expected;
                err_ext = {err[15], err};
                mag     = err[15] ? (~err_ext) + 17'd1 : err_ext;
                thr     = 16'($signed(neg16(expected)) >>> 1);
                good    = $signed({1'b0, mag}) < $signed({{2{thr[15]}}, thr});
                if (good) begin
                    if (!s.commute) begin
                        s.lock_cd = s.lock_cd - 8'd1;
                        if (s.lock_cd == 8'd0) begin
                            s.commute = 1'b1;
                            entered   = 1'b1;
                        end
                    end
                    stall = 1'b1;
                end else begin
                    s.lock_cd = i_cfg.lock_count;
                end
                period_new     = i_state.period - 16'($signed(err) >>> i_cfg.error_shift);
                s.period       = period_new;
                o_bl_ctl.write = 1'b1;
                o_bl_ctl.value = neg16(period_new);
                if (s.zero_time < period_new) begin
                    s.zero_time = period_new;
                end
                action              = ACT_ADD;
                value               = period_new + i_cfg.fixed_advance;
                s.waiting           = 1'b0;
                s.armed             = 1'b0;
                s.after_zero_reload = expected + i_cfg.advance_after_zero;
            end
        end

        o_state                  = s;
        o_result.timer_action    = action;
        o_result.timer_value     = value;
        o_result.arm_comparator  = s.armed;
        o_result.stall_reset     = stall;
        o_result.entered_commute = entered;
        o_result.in_commute      = s.commute;
        o_result.period_preset   = s.period;
        o_result.average_period  = '0;
    end

endmodule
